FILE: sv/finger_detect_capture_sequencer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the finger-detect capture sequencer
// Concurrent checks sampled on clk_i, with and without the reset guard.
// ---------------------------------------------------------------------------
`ifndef FINGER_DETECT_CAPTURE_SEQUENCER_MACROS_SVH
`define FINGER_DETECT_CAPTURE_SEQUENCER_MACROS_SVH

// check outside reset only
`define FDCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check at every edge, reset included
`define FDCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/fdcs_pkg.sv
// ---------------------------------------------------------------------------
// Finger-detect capture sequencer package
// Payload types, phase and event codes, register indexes and reset values.
// ---------------------------------------------------------------------------
package fdcs_pkg;

  localparam int unsigned LevelW    = 18;
  localparam int unsigned IndexW    = 7;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned CfgDataW  = 18;
  localparam int unsigned TimeW     = 32;

  localparam int unsigned WindowDefault    = 100;
  localparam int unsigned MaxAbsentDefault = 5;

  // phase codes
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhWait    = 2'd1;
  localparam logic [1:0] PhCollect = 2'd2;

  // event codes
  localparam logic [2:0] EvNone       = 3'd0;
  localparam logic [2:0] EvStart      = 3'd1;
  localparam logic [2:0] EvWaitTmo    = 3'd2;
  localparam logic [2:0] EvFound      = 3'd3;
  localparam logic [2:0] EvCollectTmo = 3'd4;
  localparam logic [2:0] EvLost       = 3'd5;
  localparam logic [2:0] EvWindowDone = 3'd6;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegBaseline   = 4'd0;
  localparam logic [CfgAddrW-1:0] RegEnterRatio = 4'd1;
  localparam logic [CfgAddrW-1:0] RegExitRatio  = 4'd2;
  localparam logic [CfgAddrW-1:0] RegRepeat     = 4'd3;
  localparam logic [CfgAddrW-1:0] RegWaitTmo    = 4'd4;
  localparam logic [CfgAddrW-1:0] RegCollectTmo = 4'd5;
  localparam logic [CfgAddrW-1:0] RegPeriod     = 4'd6;
  localparam logic [CfgAddrW-1:0] RegRequired   = 4'd7;

  // register reset values
  localparam logic [17:0] BaselineRst   = 18'd0;
  localparam logic [9:0]  EnterRatioRst = 10'd294;
  localparam logic [9:0]  ExitRatioRst  = 10'd269;
  localparam logic [15:0] RepeatRst     = 16'd3000;
  localparam logic [15:0] WaitTmoRst    = 16'd10000;
  localparam logic [15:0] CollectTmoRst = 16'd10000;
  localparam logic [7:0]  PeriodRst     = 8'd10;
  localparam logic [5:0]  RequiredRst   = 6'd20;

  typedef struct packed {
    logic [LevelW-1:0] ir_level;
    logic [LevelW-1:0] red_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        phase;
    logic [2:0]        event_code;
    logic              sample_valid;
    logic [IndexW-1:0] sample_index;
    logic [LevelW-1:0] ir_out;
    logic [LevelW-1:0] red_out;
    logic              window_last;
  } out_item_t;

endpackage

FILE: sv/finger_detect_capture_sequencer.sv
// ---------------------------------------------------------------------------
// Finger-detect capture sequencer
// Per-tick idle / wait / collect sequencing of IR and red optical samples.
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i/in_ready_o   | in_data_i  (one ms tick)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (one result a tick)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_addr_i, cfg_data_i
//
// One tick is taken per cycle unless a held result stalls it; its result lands
// in the output register on the next edge. The whole tick is one pass through
// the timer compares and two 18x10 threshold multiplies. A result waiting on
// out_ready_i stalls the input only while it is not being taken. Reset puts
// all but out_q at default, phase at idle; config writes are always accepted.
// ---------------------------------------------------------------------------
module finger_detect_capture_sequencer
  import fdcs_pkg::*;
#(
  parameter int unsigned WINDOW     = WindowDefault,
  parameter int unsigned MAX_ABSENT = MaxAbsentDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [IndexW-1:0] WindowLen = IndexW'(WINDOW);
  localparam logic [2:0]        AbsentMax = 3'(MAX_ABSENT);

  // configuration
  logic [9:0]  enter_q, exit_q;
  logic [15:0] repeat_q, wait_tmo_q, coll_tmo_q;
  logic [7:0]  period_q;
  logic [5:0]  required_q;

  // sequencer state
  logic [1:0]        phase_q, phase_d;
  logic [TimeW-1:0]  tick_q;
  logic [TimeW-1:0]  last_end_q, last_end_d;
  logic [TimeW-1:0]  wait_start_q, wait_start_d;
  logic [TimeW-1:0]  coll_start_q, coll_start_d;
  logic [TimeW-1:0]  last_samp_q, last_samp_d;
  logic [IndexW-1:0] fill_q, fill_d;
  logic [5:0]        present_q, present_d;
  logic [2:0]        absent_q, absent_d;
  logic [17:0]       base_used_q, base_used_d;

  logic      out_valid_q;
  out_item_t out_q, res;

  logic in_acc, cfg_acc, cfg_base_wr;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign cfg_base_wr = cfg_acc && (cfg_addr_i == RegBaseline);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // elapsed times, wrapping
  logic [TimeW-1:0] el_idle, el_wait, el_coll, el_samp;
  logic             repeat_hit, wait_tmo, coll_tmo, samp_due;

  assign el_idle = tick_q - last_end_q;
  assign el_wait = tick_q - wait_start_q;
  assign el_coll = tick_q - coll_start_q;
  assign el_samp = tick_q - last_samp_q;

  assign repeat_hit = el_idle >= {16'd0, repeat_q};
  assign wait_tmo   = el_wait >  {16'd0, wait_tmo_q};
  assign coll_tmo   = el_coll >  {16'd0, coll_tmo_q};
  assign samp_due   = el_samp >= {24'd0, period_q};

  // thresholds
  logic [17:0] base_eff;
  logic [27:0] enter_prod, exit_prod;
  logic        ir_present, ir_absent;

  assign base_eff   = (base_used_q == '0) ? in_data_i.ir_level : base_used_q;
  assign enter_prod = 28'(base_eff) * 28'(enter_q);
  assign exit_prod  = 28'(base_used_q) * 28'(exit_q);
  assign ir_present = {2'b00, in_data_i.ir_level} >= enter_prod[27:8];
  assign ir_absent  = {2'b00, in_data_i.ir_level} <  exit_prod[27:8];

  always_comb begin
    logic [5:0]        pres_n;
    logic [2:0]        abs_n;
    logic [IndexW-1:0] fill_n;
    logic              lost;
    phase_d      = phase_q;
    last_end_d   = last_end_q;
    wait_start_d = wait_start_q;
    coll_start_d = coll_start_q;
    last_samp_d  = last_samp_q;
    fill_d       = fill_q;
    present_d    = present_q;
    absent_d     = absent_q;
    base_used_d  = base_used_q;
    res          = '0;
    pres_n       = (present_q < 6'd63) ? present_q + 6'd1 : present_q;
    abs_n        = (absent_q < 3'd7) ? absent_q + 3'd1 : absent_q;
    fill_n       = fill_q;
    lost         = 1'b0;

    unique case (phase_q)
      PhIdle: begin
        if (repeat_hit) begin
          phase_d        = PhWait;
          wait_start_d   = tick_q;
          last_samp_d    = tick_q;
          fill_d         = '0;
          present_d      = '0;
          res.event_code = EvStart;
        end
      end
      PhWait: begin
        if (wait_tmo) begin
          phase_d        = PhIdle;
          last_end_d     = tick_q;
          res.event_code = EvWaitTmo;
        end else if (samp_due) begin
          last_samp_d = tick_q;
          base_used_d = base_eff;
          if (ir_present) begin
            present_d = pres_n;
            if (pres_n >= required_q) begin
              phase_d          = PhCollect;
              coll_start_d     = tick_q;
              absent_d         = '0;
              fill_d           = IndexW'(1);
              res.sample_valid = 1'b1;
              res.event_code   = EvFound;
            end
          end else begin
            present_d = '0;
          end
        end
      end
      default: begin
        if (coll_tmo) begin
          phase_d        = PhIdle;
          last_end_d     = tick_q;
          res.event_code = EvCollectTmo;
        end else if (samp_due) begin
          last_samp_d = tick_q;
          if (fill_q < WindowLen) begin
            res.sample_valid = 1'b1;
            res.sample_index = fill_q;
            fill_n           = fill_q + IndexW'(1);
            fill_d           = fill_n;
            if (ir_absent) begin
              absent_d = abs_n;
              if (abs_n >= AbsentMax) begin
                // drop the window and wait for the finger again
                phase_d        = PhWait;
                wait_start_d   = tick_q;
                absent_d       = '0;
                fill_d         = '0;
                present_d      = '0;
                res.event_code = EvLost;
                lost           = 1'b1;
              end
            end else begin
              absent_d = '0;
            end
          end
          if (!lost && fill_n >= WindowLen) begin
            res.window_last = res.sample_valid;
            phase_d         = PhIdle;
            last_end_d      = tick_q;
            fill_d          = '0;
            res.event_code  = EvWindowDone;
          end
        end
      end
    endcase

    res.phase = phase_d;
    if (res.sample_valid) begin
      res.ir_out  = in_data_i.ir_level;
      res.red_out = in_data_i.red_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enter_q      <= EnterRatioRst;
      exit_q       <= ExitRatioRst;
      repeat_q     <= RepeatRst;
      wait_tmo_q   <= WaitTmoRst;
      coll_tmo_q   <= CollectTmoRst;
      period_q     <= PeriodRst;
      required_q   <= RequiredRst;
      phase_q      <= PhIdle;
      tick_q       <= '0;
      last_end_q   <= '0;
      wait_start_q <= '0;
      coll_start_q <= '0;
      last_samp_q  <= '0;
      fill_q       <= '0;
      present_q    <= '0;
      absent_q     <= '0;
      base_used_q  <= BaselineRst;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        tick_q       <= tick_q + 32'd1;
        last_end_q   <= last_end_d;
        wait_start_q <= wait_start_d;
        coll_start_q <= coll_start_d;
        last_samp_q  <= last_samp_d;
        fill_q       <= fill_d;
        present_q    <= present_d;
        absent_q     <= absent_d;
      end
      // a baseline write reloads the working baseline
      if (cfg_base_wr) begin
        base_used_q <= cfg_data_i[17:0];
      end else if (in_acc) begin
        base_used_q <= base_used_d;
      end
      if (cfg_acc) begin
        case (cfg_addr_i)
          RegEnterRatio: enter_q    <= cfg_data_i[9:0];
          RegExitRatio:  exit_q     <= cfg_data_i[9:0];
          RegRepeat:     repeat_q   <= cfg_data_i[15:0];
          RegWaitTmo:    wait_tmo_q <= cfg_data_i[15:0];
          RegCollectTmo: coll_tmo_q <= cfg_data_i[15:0];
          RegPeriod:     period_q   <= cfg_data_i[7:0];
          RegRequired:   required_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload register, loaded on every accepted request
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
    end
  end

  logic res_last, res_last_ok, res_empty, res_fields_zero;

  assign res_last        = out_valid_q && out_q.window_last;
  assign res_last_ok     = out_q.sample_valid && (out_q.event_code == EvWindowDone);
  assign res_empty       = out_valid_q && !out_q.sample_valid;
  assign res_fields_zero = (out_q.sample_index == '0) && (out_q.ir_out == '0) &&
                           (out_q.red_out == '0) && !out_q.window_last;

`include "finger_detect_capture_sequencer_macros.svh"

  `FDCS_ASSERT(a_tick_advance, in_acc |=> tick_q == $past(tick_q) + 32'd1, "tick stuck")
  `FDCS_ASSERT(a_phase_match, in_acc |=> out_q.phase == phase_q, "result phase mismatch")
  `FDCS_ASSERT(a_last_is_done, res_last |-> res_last_ok, "stray window_last")
  `FDCS_ASSERT_ALWAYS(a_empty_fields, res_empty |-> res_fields_zero, "stray sample fields")

endmodule

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// Finger-detect capture sequencer testbench
// Streams millisecond ticks of IR/red readings through the sequencer under
// random stalls on both sides, predicts every per-tick result with a local
// copy of the phase logic, and compares each field of each result in order.
// ---------------------------------------------------------------------------
module tb_top;
  import fdcs_pkg::*;

  localparam int unsigned WinLen      = WindowDefault;
  localparam int unsigned AbsentLimit = MaxAbsentDefault;
  localparam int unsigned LevelMax    = 262143;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned ErrPrintMax = 40;

  // register slots the block does not decode
  localparam logic [CfgAddrW-1:0] RegBeyond   = RegRequired + 4'd1;
  localparam logic [CfgAddrW-1:0] RegTopIndex = '1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int unsigned cycle_cnt    = 0;
  int unsigned mismatch_cnt = 0;
  logic        quiet;

  in_item_t  tick_q[$];
  out_item_t seq_out_q[$];
  out_item_t tick_res;
  out_item_t want_res;

  // level bands for the current phase of stimulus
  int unsigned hi_floor, hi_top, lo_floor, lo_ceil;

  // predicted register file
  logic [17:0] cfg_baseline = BaselineRst;
  logic [9:0]  cfg_enter    = EnterRatioRst;
  logic [9:0]  cfg_exit     = ExitRatioRst;
  logic [15:0] cfg_repeat   = RepeatRst;
  logic [15:0] cfg_wait     = WaitTmoRst;
  logic [15:0] cfg_collect  = CollectTmoRst;
  logic [7:0]  cfg_period   = PeriodRst;
  logic [5:0]  cfg_required = RequiredRst;

  // predicted sequencer state
  logic [1:0]  cur_phase   = PhIdle;
  logic [31:0] tick_ms     = '0;
  logic [31:0] end_ms      = '0;
  logic [31:0] wait_t0     = '0;
  logic [31:0] collect_t0  = '0;
  logic [31:0] sample_t0   = '0;
  int unsigned fill_cnt    = 0;
  int unsigned present_run = 0;
  int unsigned absent_run  = 0;
  logic [17:0] base_live   = BaselineRst;

  finger_detect_capture_sequencer #(
    .WINDOW    (WinLen),
    .MAX_ABSENT(AbsentLimit)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_addr_i (cfg_addr),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  assign quiet = (cycle_cnt >= 1200) && (cycle_cnt < 2000);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("finger_detect_capture_sequencer verification failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= ErrPrintMax)
      $display("MISMATCH %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  // One millisecond tick of the sequencer: update state, build the result.
  task automatic sequencer_tick(input in_item_t item, output out_item_t res);
    logic [31:0] now_ms;
    logic [31:0] thr;
    bit          lost;
    now_ms = tick_ms;
    res    = '0;
    lost   = 1'b0;
    case (cur_phase)
      PhIdle: begin
        if (now_ms - end_ms >= 32'(cfg_repeat)) begin
          cur_phase      = PhWait;
          wait_t0        = now_ms;
          sample_t0      = now_ms;
          fill_cnt       = 0;
          present_run    = 0;
          res.event_code = EvStart;
        end
      end
      PhWait: begin
        if (now_ms - wait_t0 > 32'(cfg_wait)) begin
          cur_phase      = PhIdle;
          end_ms         = now_ms;
          res.event_code = EvWaitTmo;
        end else if (now_ms - sample_t0 >= 32'(cfg_period)) begin
          sample_t0 = now_ms;
          // latch the first reading as the no-finger level
          if (base_live == '0) base_live = item.ir_level;
          thr = (32'(base_live) * 32'(cfg_enter)) >> 8;
          if (32'(item.ir_level) >= thr) begin
            if (present_run < 63) present_run++;
            if (present_run >= 32'(cfg_required)) begin
              cur_phase        = PhCollect;
              collect_t0       = now_ms;
              absent_run       = 0;
              res.sample_valid = 1'b1;
              res.sample_index = '0;
              fill_cnt         = 1;
              res.event_code   = EvFound;
            end
          end else begin
            present_run = 0;
          end
        end
      end
      default: begin
        if (now_ms - collect_t0 > 32'(cfg_collect)) begin
          cur_phase      = PhIdle;
          end_ms         = now_ms;
          res.event_code = EvCollectTmo;
        end else if (now_ms - sample_t0 >= 32'(cfg_period)) begin
          sample_t0 = now_ms;
          if (fill_cnt < WinLen) begin
            res.sample_valid = 1'b1;
            res.sample_index = 7'(fill_cnt);
            fill_cnt++;
            thr = (32'(base_live) * 32'(cfg_exit)) >> 8;
            if (32'(item.ir_level) < thr) begin
              if (absent_run < 7) absent_run++;
              if (absent_run >= AbsentLimit) begin
                cur_phase      = PhWait;
                wait_t0        = now_ms;
                absent_run     = 0;
                fill_cnt       = 0;
                present_run    = 0;
                res.event_code = EvLost;
                lost           = 1'b1;
              end
            end else begin
              absent_run = 0;
            end
          end
          // finger lost wins over a full window
          if (!lost && fill_cnt >= WinLen) begin
            res.window_last = res.sample_valid;
            cur_phase       = PhIdle;
            end_ms          = now_ms;
            fill_cnt        = 0;
            res.event_code  = EvWindowDone;
          end
        end
      end
    endcase
    tick_ms   = now_ms + 32'd1;
    res.phase = cur_phase;
    if (res.sample_valid) begin
      res.ir_out  = item.ir_level;
      res.red_out = item.red_level;
    end
  endtask

  // Request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        sequencer_tick(in_data, tick_res);
        seq_out_q.push_back(tick_res);
      end
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && (quiet || $urandom_range(99) >= 28)) begin
          in_valid <= 1'b1;
          in_data  <= tick_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (seq_out_q.size() == 0) begin
          flag_mismatch("result with none pending", 0, 0);
        end else begin
          want_res = seq_out_q.pop_front();
          if (out_data.phase !== want_res.phase)
            flag_mismatch("phase", out_data.phase, want_res.phase);
          if (out_data.event_code !== want_res.event_code)
            flag_mismatch("event_code", out_data.event_code, want_res.event_code);
          if (out_data.sample_valid !== want_res.sample_valid)
            flag_mismatch("sample_valid", out_data.sample_valid, want_res.sample_valid);
          if (out_data.sample_index !== want_res.sample_index)
            flag_mismatch("sample_index", out_data.sample_index, want_res.sample_index);
          if (out_data.ir_out !== want_res.ir_out)
            flag_mismatch("ir_out", out_data.ir_out, want_res.ir_out);
          if (out_data.red_out !== want_res.red_out)
            flag_mismatch("red_out", out_data.red_out, want_res.red_out);
          if (out_data.window_last !== want_res.window_last)
            flag_mismatch("window_last", out_data.window_last, want_res.window_last);
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 28);
    end
  end

  function automatic logic [CfgDataW-1:0] with_junk(input int unsigned value,
                                                    input int unsigned w);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'(value);
    // fill unused upper bits now and then; the block must drop them
    if ($urandom_range(1) == 1)
      for (int unsigned b = w; b < CfgDataW; b++) d[b] = 1'($urandom_range(1));
    return d;
  endfunction

  function automatic logic [17:0] pick_level(input bit present);
    if (present) return 18'($urandom_range(hi_top, hi_floor));
    if (lo_ceil == 0) return '0;
    return 18'($urandom_range(lo_ceil - 1, lo_floor));
  endfunction

  task automatic push_tick(input logic [17:0] ir, input logic [17:0] red);
    in_item_t t;
    t.ir_level  = ir;
    t.red_level = red;
    tick_q.push_back(t);
  endtask

  // Hold until every request has gone in and every result has come back.
  task automatic drain();
    while (tick_q.size() != 0 || in_valid || seq_out_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgAddrW-1:0] addr,
                           input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (addr)
      RegBaseline: begin
        cfg_baseline = data[17:0];
        base_live    = data[17:0];
      end
      RegEnterRatio: cfg_enter    = data[9:0];
      RegExitRatio:  cfg_exit     = data[9:0];
      RegRepeat:     cfg_repeat   = data[15:0];
      RegWaitTmo:    cfg_wait     = data[15:0];
      RegCollectTmo: cfg_collect  = data[15:0];
      RegPeriod:     cfg_period   = data[7:0];
      RegRequired:   cfg_required = data[5:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int unsigned bl, input int unsigned en,
                           input int unsigned ex, input int unsigned rep,
                           input int unsigned wt, input int unsigned ct,
                           input int unsigned per, input int unsigned req);
    write_reg(RegBaseline,   with_junk(bl, 18));
    write_reg(RegEnterRatio, with_junk(en, 10));
    write_reg(RegExitRatio,  with_junk(ex, 10));
    write_reg(RegRepeat,     with_junk(rep, 16));
    write_reg(RegWaitTmo,    with_junk(wt, 16));
    write_reg(RegCollectTmo, with_junk(ct, 16));
    write_reg(RegPeriod,     with_junk(per, 8));
    write_reg(RegRequired,   with_junk(req, 6));
    write_reg($urandom_range(1) ? RegBeyond : RegTopIndex, CfgDataW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned p, k, r, len, dip, dip_max, n, count;
    int unsigned bl, en, ex, rep, wt, ct, per, req, b_eff, hi_ratio, lo_ratio;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start at once, find on the first sample, lose the finger, edge of exit level.
    write_all(1000, 256, 1023, 0, 65535, 65535, 0, 1);
    push_tick(0, LevelMax);
    push_tick(LevelMax, 0);
    repeat (5) push_tick(0, 18'($urandom_range(LevelMax)));
    push_tick(3996, 18'($urandom_range(LevelMax)));
    push_tick(3995, 18'($urandom_range(LevelMax)));
    push_tick(3996, 18'($urandom_range(LevelMax)));
    push_tick(1, LevelMax);
    drain();

    // Zero collect timeout and period, zero required count, full-scale baseline.
    write_all(LevelMax, 256, 256, 0, 1, 0, 0, 0);
    push_tick(18'($urandom_range(LevelMax)), 0);
    push_tick(0, LevelMax);
    push_tick(LevelMax, LevelMax);
    push_tick(0, 0);
    push_tick(LevelMax, 18'($urandom_range(LevelMax)));
    push_tick(0, 18'($urandom_range(LevelMax)));
    push_tick(0, 0);
    push_tick(LevelMax, 0);
    drain();

    for (p = 0; p < 14; p++) begin
      bl = (p % 4 == 0) ? 0 : $urandom_range(150000, 1000);
      if (p == 5) bl = 1;
      if (p == 7) bl = LevelMax;
      en = $urandom_range(420, 270);
      if (p == 2) en = 1023;
      if (p == 6) en = 256;
      ex = $urandom_range(en, 256);
      if (p == 2) ex = 256;
      if (p == 6) ex = 1023;
      rep = $urandom_range(40, 0);
      if (p == 1) rep = 0;
      if (p == 9) rep = 65535;
      wt = $urandom_range(400, 60);
      if (p == 3) wt = 0;
      if (p == 8) wt = 65535;
      if (p == 13) wt = 600;
      ct = $urandom_range(500, 80);
      if (p == 10) ct = 0;
      if (p == 8) ct = 65535;
      per = $urandom_range(3, 1);
      if (p == 1) per = 0;
      if (p == 11) per = 255;
      if (p == 12) per = $urandom_range(9, 4);
      if (p == 13) per = 1;
      req = $urandom_range(12, 1);
      if (p == 1) req = 0;
      if (p == 13) req = 63;
      write_all(bl, en, ex, rep, wt, ct, per, req);

      // derive finger-present and finger-absent bands from the thresholds
      b_eff    = (bl == 0) ? 40000 : bl;
      hi_ratio = (en > ex) ? en : ex;
      lo_ratio = (en > ex) ? ex : en;
      hi_floor = (b_eff * hi_ratio) >> 8;
      if (hi_floor > LevelMax) hi_floor = LevelMax;
      hi_top = hi_floor + hi_floor / 4 + 8;
      if (hi_top > LevelMax) hi_top = LevelMax;
      if (bl == 0) begin
        lo_ceil  = b_eff + 1;
        lo_floor = b_eff - b_eff / 16;
      end else begin
        lo_ceil  = (b_eff * lo_ratio) >> 8;
        if (lo_ceil > LevelMax + 1) lo_ceil = LevelMax + 1;
        lo_floor = lo_ceil / 2;
      end
      dip_max = (per == 0) ? 7 : ((7 * per > 60) ? 60 : 7 * per);

      n     = (p == 9 || p == 11) ? 30 : 105;
      count = 0;
      while (count < n) begin
        r = $urandom_range(99);
        if (r < 65) begin
          // finger on the sensor with short dips
          len = $urandom_range(120, 20);
          if (len > n - count) len = n - count;
          dip = 0;
          for (k = 0; k < len; k++) begin
            if (dip == 0 && p != 13 && $urandom_range(99) < 4)
              dip = $urandom_range(dip_max, 1);
            if (dip != 0) begin
              push_tick(pick_level(1'b0), 18'($urandom_range(LevelMax)));
              dip--;
            end else begin
              push_tick(pick_level(1'b1), 18'($urandom_range(LevelMax)));
            end
          end
        end else if (r < 88) begin
          len = $urandom_range(40, 5);
          if (len > n - count) len = n - count;
          for (k = 0; k < len; k++)
            push_tick(pick_level(1'b0), 18'($urandom_range(LevelMax)));
        end else begin
          len = $urandom_range(10, 1);
          if (len > n - count) len = n - count;
          for (k = 0; k < len; k++)
            push_tick(18'($urandom_range(LevelMax)), 18'($urandom_range(LevelMax)));
        end
        count += len;
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("finger_detect_capture_sequencer verification clean");
    end else begin
      $display("finger_detect_capture_sequencer verification failed");
    end
    $finish;
  end

endmodule

FILE: finger_detect_capture_sequencer.f
+incdir+sv
sv/fdcs_pkg.sv
sv/finger_detect_capture_sequencer.sv
bench/tb_top.sv
